// ----- hdl/line_rasterizer_defines.svh -----
// Assertion macros for the checker file of the line rasterizer.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_rasterizer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_rasterizer: next-cycle check failed");

`endif

// ----- hdl/lr_pkg.sv -----
package lr_pkg;

    // Default coordinate width.
    localparam int LR_COORD_BITS = 6;

    // Controller states.
    typedef enum logic [1:0] {
        LR_IDLE,
        LR_SETUP,
        LR_DRAW
    } lr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } lr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } lr_status_t;

endpackage

// ----- hdl/lr_ctrl.sv -----
module lr_ctrl
    import lr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       line_valid,
    output logic       line_stall,
    output logic       pixel_valid,
    input  logic       pixel_stall,
    input  lr_status_t status,
    output lr_cmd_t    cmd
);

    lr_state_t state_reg;
    lr_state_t state_next;
    logic      line_take;
    logic      pixel_take;

    // Handshake completions.
    assign line_take  = line_valid && (state_reg == LR_IDLE);
    assign pixel_take = (state_reg == LR_DRAW) && !pixel_stall;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LR_IDLE:
            begin
                if (line_take)
                begin
                    state_next = LR_SETUP;
                end
            end
            LR_SETUP:
            begin
                state_next = LR_DRAW;
            end
            LR_DRAW:
            begin
                if (pixel_take && status.last)
                begin
                    state_next = LR_IDLE;
                end
            end
            default:
            begin
                state_next = LR_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        line_stall  = (state_reg != LR_IDLE);
        pixel_valid = (state_reg == LR_DRAW);
        cmd.load    = line_take;
        cmd.setup   = (state_reg == LR_SETUP);
        cmd.step    = pixel_take;
    end

endmodule

// ----- hdl/lr_datapath.sv -----
module lr_datapath
    import lr_pkg::*;
#(
    parameter int COORD_BITS = LR_COORD_BITS
)
(
    input  logic                  clk,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  lr_cmd_t               cmd,
    output lr_status_t            status,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y
);

    // Decision variable spans roughly -2*major .. 2*minor.
    localparam int DEC_BITS = COORD_BITS + 3;

    logic [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg, cnt_reg;
    logic signed [DEC_BITS-1:0] dec_reg, inc_a_reg, inc_b_reg;
    logic steep_reg, y_down_reg;

    logic                  swap;
    logic [COORD_BITS-1:0] ax, ay, bx, by, dx, ady, major, minor, start_y_sel;
    logic                  y_down, steep;
    logic signed [DEC_BITS-1:0] major_ext, minor_ext;
    logic                  minor_move;
    logic [COORD_BITS-1:0] y_step;

    // Setup: order endpoints by x, then find the major axis and the deltas.
    always_comb
    begin
        swap   = sx_reg > ex_reg;
        ax     = swap ? ex_reg : sx_reg;
        ay     = swap ? ey_reg : sy_reg;
        bx     = swap ? sx_reg : ex_reg;
        by     = swap ? sy_reg : ey_reg;
        dx     = bx - ax;
        y_down = (ay > by) && (dx != '0);
        ady    = (ay > by) ? (ay - by) : (by - ay);
        // A vertical line is drawn upward from its lower end.
        start_y_sel = ((ay > by) && (dx == '0)) ? by : ay;
        steep     = ady > dx;
        major     = steep ? ady : dx;
        minor     = steep ? dx : ady;
        major_ext = DEC_BITS'(major);
        minor_ext = DEC_BITS'(minor);
    end

    // Step: the minor coordinate moves when the decision variable is positive.
    assign minor_move = !(dec_reg[DEC_BITS-1] || (dec_reg == '0));
    assign y_step     = y_down_reg ? (py_reg - COORD_BITS'(1)) : (py_reg + COORD_BITS'(1));

    // Endpoint capture and walk registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg <= start_x;
            sy_reg <= start_y;
            ex_reg <= end_x;
            ey_reg <= end_y;
        end
        if (cmd.setup)
        begin
            px_reg     <= ax;
            py_reg     <= start_y_sel;
            cnt_reg    <= major;
            steep_reg  <= steep;
            y_down_reg <= y_down;
            dec_reg    <= (minor_ext <<< 1) - major_ext;
            inc_a_reg  <= minor_ext <<< 1;
            inc_b_reg  <= (minor_ext <<< 1) - (major_ext <<< 1);
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg - COORD_BITS'(1);
            if (minor_move)
            begin
                dec_reg <= dec_reg + inc_b_reg;
            end
            else
            begin
                dec_reg <= dec_reg + inc_a_reg;
            end
            if (steep_reg)
            begin
                py_reg <= y_step;
                if (minor_move)
                begin
                    px_reg <= px_reg + COORD_BITS'(1);
                end
            end
            else
            begin
                px_reg <= px_reg + COORD_BITS'(1);
                if (minor_move)
                begin
                    py_reg <= y_step;
                end
            end
        end
    end

    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign status.last = (cnt_reg == '0);

endmodule

// ----- hdl/line_rasterizer.sv -----
// After a line transaction is accepted in the idle state, the controller passes through the setup
// state, in which the walk registers are loaded, to the draw state, where pixels are offered.
// Throughput: one pixel per cycle while pixel_stall is low; a line has n pixels,
// n = max(|dx|,|dy|) + 1, counted down by the walk counter.
// A new line is accepted in the cycle after its last pixel transaction.
// Reset (rst_n low, asynchronous) returns the controller to idle; no clearing pass.
module line_rasterizer
    import lr_pkg::*;
#(
    parameter int COORD_BITS = LR_COORD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  line_valid,
    output logic                  line_stall,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);

    lr_cmd_t    cmd;
    lr_status_t status;

    // Sequencer.
    lr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_valid  (line_valid),
        .line_stall  (line_stall),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // Coordinate walker.
    lr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk     (clk),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .cmd     (cmd),
        .status  (status),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y)
    );

    assign last_pixel = status.last;

endmodule

// ----- hdl/lr_checker.sv -----
`include "line_rasterizer_defines.svh"

module lr_checker
    import lr_pkg::*;
#(
    parameter int COORD_BITS = LR_COORD_BITS
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  line_valid,
    input logic                  line_stall,
    input logic                  pixel_valid,
    input logic                  pixel_stall,
    input logic [COORD_BITS-1:0] pixel_x,
    input logic [COORD_BITS-1:0] pixel_y,
    input logic                  last_pixel
);

    // A stalled pixel transaction holds its payload.
    `LR_ASSERT_NEXT(a_pixel_hold, clk, rst_n,
        pixel_valid && pixel_stall,
        pixel_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))

    // A line is taken only when no pixel is pending.
    `LR_ASSERT_NOW(a_line_when_free, clk, rst_n, line_valid && !line_stall, !pixel_valid)

    // The setup cycle follows an accepted line.
    `LR_ASSERT_NEXT(a_setup_gap, clk, rst_n,
        line_valid && !line_stall,
        !pixel_valid && line_stall)

    // The last pixel closes the line; any other pixel is followed by the next one.
    `LR_ASSERT_NEXT(a_line_end, clk, rst_n,
        pixel_valid && !pixel_stall && last_pixel,
        !pixel_valid && !line_stall)
    `LR_ASSERT_NEXT(a_line_go_on, clk, rst_n,
        pixel_valid && !pixel_stall && !last_pixel,
        pixel_valid)

endmodule

bind line_rasterizer lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (.*);
